>>> rtl/lsct_pkg.sv
// Shared constants, types and helper functions for the line-sensor centroid tracker.
package lsct_pkg;

    localparam int Channels = 7;
    localparam int DivSteps = 7;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 8;
    localparam int InDataWidth = 8;
    localparam int OutDataWidth = 64;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CfgPolarity  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgCornerEn  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CfgMagnitude = 2'd2;

    localparam logic [6:0] LowCornerMask  = 7'h0F;
    localparam logic [6:0] HighCornerMask = 7'h78;

    localparam logic [7:0] MagnitudeReset = 8'd50;

    // output word bit positions, lowest field first
    localparam int RawLsb     = 0;
    localparam int ActLsb     = 7;
    localparam int TotalLsb   = 14;
    localparam int PresentBit = 17;
    localparam int ErrLsb     = 18;
    localparam int FoundBit   = 27;
    localparam int SideLsb    = 28;
    localparam int SampleLsb  = 30;
    localparam int PadLsb     = 62;

    typedef struct packed {
        logic load;    // capture the input word
        logic calc;    // form count and weighted sum
        logic step;    // one divide iteration
        logic commit;  // write the output word and state
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

    function automatic logic signed [7:0] chan_weight(input logic [2:0] idx);
        logic signed [7:0] w;
        begin
            case (idx)
                3'd0:    w = 8'sd50;
                3'd1:    w = 8'sd33;
                3'd2:    w = 8'sd16;
                3'd3:    w = 8'sd0;
                3'd4:    w = -8'sd16;
                3'd5:    w = -8'sd33;
                3'd6:    w = -8'sd50;
                default: w = 8'sd0;
            endcase
            return w;
        end
    endfunction

endpackage

>>> rtl/lsct_ctrl.sv
// Sequencer for the centroid tracker: handshakes and datapath commands.
module lsct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output lsct_pkg::t_dp_cmd o_cmd,
    input  lsct_pkg::t_dp_sts i_sts
);
    import lsct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_s_ready;
    logic   r_m_valid;
    logic   out_free;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_s_tready = r_s_ready;
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_s_tvalid && r_s_ready;
        o_cmd.calc   = (r_state == S_CALC);
        o_cmd.step   = (r_state == S_DIV);
        o_cmd.commit = (r_state == S_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            // refill on a commit, otherwise drop the word once taken
            if (o_cmd.commit) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && r_s_ready) begin
                        r_state   <= S_CALC;
                        r_s_ready <= 1'b0;
                    end
                end
                S_CALC: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state   <= S_IDLE;
                        r_s_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/lsct_dp.sv
// Datapath: configuration, weighted sum, serial divider, corner rule, output word.
module lsct_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [lsct_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [lsct_pkg::CfgDataWidth-1:0]   i_cfg_data,
    input  logic [lsct_pkg::InDataWidth-1:0]    i_s_tdata,
    output logic [lsct_pkg::OutDataWidth-1:0]   o_m_tdata,
    input  lsct_pkg::t_dp_cmd                   i_cmd,
    output lsct_pkg::t_dp_sts                   o_sts
);
    import lsct_pkg::*;

    logic        r_polarity;
    logic        r_corner_en;
    logic [7:0]  r_magnitude;

    logic [6:0]  r_raw;
    logic [6:0]  r_act;
    logic [2:0]  r_total;
    logic        r_neg;
    logic [6:0]  r_dq;
    logic [2:0]  r_rem;
    logic [2:0]  r_step;
    logic signed [8:0] r_held;
    logic [31:0] r_sample;
    logic [OutDataWidth-1:0] r_out;

    logic signed [7:0] sum_c;
    logic [2:0]  count_c;
    logic [7:0]  abs_c;
    logic [6:0]  act_in;

    logic [3:0]  rem_sh;
    logic [3:0]  rem_diff;
    logic        q_bit;

    logic signed [8:0] cent;
    logic signed [8:0] err_c;
    logic signed [8:0] n_held;
    logic [31:0] n_sample;
    logic        low_grp;
    logic        high_grp;
    logic        present;
    logic        found;
    logic [1:0]  side;

    assign act_in = r_polarity ? ~i_s_tdata[6:0] : i_s_tdata[6:0];

    // weighted sum and population count of the active mask
    always_comb begin
        sum_c   = 8'sd0;
        count_c = 3'd0;
        for (int i = 0; i < Channels; i++) begin
            if (r_act[i]) begin
                sum_c   = sum_c + chan_weight(3'(i));
                count_c = count_c + 3'd1;
            end
        end
        abs_c = sum_c[7] ? 8'(-sum_c) : 8'(sum_c);
    end

    // restoring divide, one quotient bit per step
    assign rem_sh   = {r_rem, r_dq[6]};
    assign rem_diff = rem_sh - {1'b0, r_total};
    assign q_bit    = (rem_sh >= {1'b0, r_total});

    assign o_sts.div_last = (r_step == 3'(DivSteps - 1));

    always_comb begin
        cent     = r_neg ? -$signed({2'b00, r_dq}) : $signed({2'b00, r_dq});
        low_grp  = (r_act & LowCornerMask) == LowCornerMask;
        high_grp = (r_act & HighCornerMask) == HighCornerMask;
        present  = (r_total != 3'd0);
        err_c    = cent;
        found    = 1'b0;
        side     = 2'b00;
        if (r_corner_en && low_grp && !high_grp) begin
            err_c = $signed({1'b0, r_magnitude});
            found = 1'b1;
            side  = 2'b01;
        end else if (r_corner_en && high_grp && !low_grp) begin
            err_c = -$signed({1'b0, r_magnitude});
            found = 1'b1;
            side  = 2'b11;
        end
        if (!present) begin
            found = 1'b0;
            side  = 2'b00;
        end
        n_held   = present ? err_c : r_held;
        n_sample = r_sample + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity  <= 1'b0;
            r_corner_en <= 1'b1;
            r_magnitude <= MagnitudeReset;
            r_held      <= 9'sd0;
            r_sample    <= 32'd0;
            r_step      <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgPolarity:  r_polarity  <= i_cfg_data[0];
                    CfgCornerEn:  r_corner_en <= i_cfg_data[0];
                    CfgMagnitude: r_magnitude <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.calc) begin
                r_step <= 3'd0;
            end else if (i_cmd.step) begin
                r_step <= r_step + 3'd1;
            end
            if (i_cmd.commit) begin
                r_held   <= n_held;
                r_sample <= n_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw <= i_s_tdata[6:0];
            r_act <= act_in;
        end
        if (i_cmd.calc) begin
            r_total <= count_c;
            r_neg   <= sum_c[7];
            r_dq    <= abs_c[6:0];
            r_rem   <= 3'd0;
        end else if (i_cmd.step) begin
            r_rem <= q_bit ? rem_diff[2:0] : rem_sh[2:0];
            r_dq  <= {r_dq[5:0], q_bit};
        end
        if (i_cmd.commit) begin
            r_out <= {2'b00, n_sample, side, found, n_held, present, r_total, r_act, r_raw};
        end
    end

    assign o_m_tdata = r_out;

endmodule

>>> rtl/line_sensor_centroid_tracker_top.sv
// Top level of the seven-channel line-sensor centroid tracker.
//
//  channel  direction  handshake              payload
//  s        in         i_s_tvalid/o_s_tready  i_s_tdata[6:0] sensor levels
//  m        out        o_m_tvalid/i_m_tready  o_m_tdata, 62 bits of result fields
//  cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  From accept to result an item passes through one capture, one sum, seven iterations
//  of the serial divider and one commit when the output is free; the next word
//  is taken the cycle after commit. Synchronous active-low reset restores
//  config defaults and clears held error, sample count and control.
//  A stalled output word holds; the finished item waits in the commit step until
//  the output register is free, and no input word is taken meanwhile.
module line_sensor_centroid_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // fields from bit 0: sensor_levels[6:0], zero pad [7]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lsct_pkg::InDataWidth-1:0]    i_s_tdata,
    // fields from bit 0: raw_levels[6:0], active_channels[13:7], active_total[16:14],
    // line_present[17], track_error[26:18], corner_found[27], corner_side[29:28],
    // sample_number[61:30], zero pad [63:62]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lsct_pkg::OutDataWidth-1:0]   o_m_tdata,
    // register write port
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lsct_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [lsct_pkg::CfgDataWidth-1:0]   i_cfg_data
);
    import lsct_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    lsct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lsct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> rtl/lsct_checker.sv
// Port-level checks for the centroid tracker, bound to its top level.
module lsct_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [lsct_pkg::OutDataWidth-1:0]   o_m_tdata
);
    import lsct_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output changed");

    // presence flag matches count, corner needs a line, pad bits are zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[PresentBit] == (o_m_tdata[16:14] != 3'd0))
                        && (!o_m_tdata[FoundBit] || o_m_tdata[PresentBit])
                        && (o_m_tdata[63:62] == 2'b00)))
        else $error("inconsistent output fields");

endmodule

bind line_sensor_centroid_tracker_top lsct_checker u_lsct_checker (.*);

>>> test/lsct_result_checker.sv
// Checker for the line-sensor tracker: predicts each result word and compares it field by field.
module lsct_result_checker
    import lsct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [InDataWidth-1:0]   i_s_tdata,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [OutDataWidth-1:0]  i_m_tdata,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_corners
);

    localparam logic [1:0] SideNone     = 2'b00;
    localparam logic [1:0] SideLowTurn  = 2'b01;
    localparam logic [1:0] SideHighTurn = 2'b11;
    localparam int         PrintCap     = 40;

    typedef struct packed {
        logic [6:0]        raw;
        logic [6:0]        act;
        logic [2:0]        total;
        logic              present;
        logic signed [8:0] err;
        logic              found;
        logic [1:0]        side;
        logic [31:0]       number;
        logic [1:0]        pad;
    } t_track_result;

    // private copy of the register file and of the tracking state
    logic              pol_low;
    logic              corner_en;
    logic [7:0]        corner_mag;
    logic signed [8:0] held_err;
    logic [31:0]       sample_cnt;

    t_track_result expected_q [$];

    function automatic int pull_of(input int chan);
        case (chan)
            0:       return 50;
            1:       return 33;
            2:       return 16;
            4:       return -16;
            5:       return -33;
            6:       return -50;
            default: return 0;
        endcase
    endfunction

    // centroid of the active channels, with the corner override; updates held state
    function automatic t_track_result track_sample(input logic [6:0] levels);
        t_track_result r;
        int            sum;
        int            cnt;
        int            err;
        logic          low_grp;
        logic          high_grp;
        r       = '0;
        r.raw   = levels;
        r.act   = pol_low ? ~levels : levels;
        r.side  = SideNone;
        sum     = 0;
        cnt     = 0;
        for (int c = 0; c < Channels; c++) begin
            if (r.act[c]) begin
                sum += pull_of(c);
                cnt++;
            end
        end
        if (cnt > 0) begin
            err      = sum / cnt;
            low_grp  = (r.act & LowCornerMask) == LowCornerMask;
            high_grp = (r.act & HighCornerMask) == HighCornerMask;
            if (corner_en && low_grp && !high_grp) begin
                err     = int'(corner_mag);
                r.found = 1'b1;
                r.side  = SideLowTurn;
            end else if (corner_en && high_grp && !low_grp) begin
                err     = -int'(corner_mag);
                r.found = 1'b1;
                r.side  = SideHighTurn;
            end
            held_err = err[8:0];
        end
        sample_cnt = sample_cnt + 32'd1;
        r.total    = cnt[2:0];
        r.present  = cnt > 0;
        r.err      = held_err;
        r.number   = sample_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_errors < PrintCap) begin
            $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        end
        o_errors++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_track_result got;
        t_track_result want;
        if (!i_rst_n) begin
            pol_low    = 1'b0;
            corner_en  = 1'b1;
            corner_mag = MagnitudeReset;
            held_err   = '0;
            sample_cnt = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CfgPolarity:  pol_low    = i_cfg_data[0];
                    CfgCornerEn:  corner_en  = i_cfg_data[0];
                    CfgMagnitude: corner_mag = i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(track_sample(i_s_tdata[6:0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.raw     = i_m_tdata[RawLsb +: 7];
                got.act     = i_m_tdata[ActLsb +: 7];
                got.total   = i_m_tdata[TotalLsb +: 3];
                got.present = i_m_tdata[PresentBit];
                got.err     = i_m_tdata[ErrLsb +: 9];
                got.found   = i_m_tdata[FoundBit];
                got.side    = i_m_tdata[SideLsb +: 2];
                got.number  = i_m_tdata[SampleLsb +: 32];
                got.pad     = i_m_tdata[PadLsb +: 2];
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", got.number, '0);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("raw_levels", 32'(got.raw), 32'(want.raw));
                    compare_field("active_channels", 32'(got.act), 32'(want.act));
                    compare_field("active_total", 32'(got.total), 32'(want.total));
                    compare_field("line_present", 32'(got.present), 32'(want.present));
                    compare_field("track_error", 32'(got.err), 32'(want.err));
                    compare_field("corner_found", 32'(got.found), 32'(want.found));
                    compare_field("corner_side", 32'(got.side), 32'(want.side));
                    compare_field("sample_number", got.number, want.number);
                    compare_field("pad bits", 32'(got.pad), 32'(want.pad));
                    o_checked++;
                    if (want.found) begin
                        o_corners++;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

>>> test/line_sensor_centroid_tracker_top_tb.sv
// Testbench top for the line-sensor tracker: clock, reset, stimulus, receiver stalls, verdict.
module line_sensor_centroid_tracker_top_tb;
    import lsct_pkg::*;

    // index past the end of the register file; writes there must be ignored
    localparam logic [CfgIndexWidth-1:0] CfgSpare = 2'd3;
    localparam int ResultLatency = 10;
    localparam int HoldCycles    = 300;
    localparam int DirectedCount = 20;

    typedef enum logic [1:0] {
        SinkOpen,
        SinkCoin,
        SinkSparse,
        SinkPattern
    } t_sink_mode;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [InDataWidth-1:0]   i_s_tdata   = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b0;
    logic [OutDataWidth-1:0]  o_m_tdata;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0]  i_cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int corners;

    // sender state
    int burst_left = 0;
    int phases_run = 0;

    // receiver state: the stimulus flips hold_toggle to ask for a long hold-off
    logic       hold_toggle = 1'b0;
    logic       hold_seen   = 1'b0;
    int         hold_left   = 0;
    int         mode_left   = 0;
    int         rx_cycle    = 0;
    t_sink_mode sink_mode   = SinkOpen;

    // corners, centroid extremes, truncation toward zero and no-line holds
    logic [6:0] directed_levels [DirectedCount] = '{
        7'h00, 7'h7F, 7'h01, 7'h40, 7'h0F, 7'h78, 7'h00, 7'h03, 7'h60, 7'h06,
        7'h30, 7'h08, 7'h1F, 7'h7C, 7'h55, 7'h2A, 7'h05, 7'h50, 7'h15, 7'h3E
    };

    line_sensor_centroid_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lsct_result_checker checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_corners   (corners)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: a long hold-off when asked, otherwise random stretches of
    // open, coin-flip, sparse and fixed-pattern readiness.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            hold_left  <= HoldCycles;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode <= t_sink_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (sink_mode)
                SinkOpen:    i_m_tready <= 1'b1;
                SinkCoin:    i_m_tready <= 1'($urandom_range(0, 1));
                SinkSparse:  i_m_tready <= ($urandom_range(0, 3) == 0);
                SinkPattern: i_m_tready <= rx_cycle[2] ^ rx_cycle[0];
                default:     i_m_tready <= 1'b1;
            endcase
        end
    end

    // Offer one sample word and hold it until taken. A burst that runs out
    // drops valid for a random gap before the next word.
    task automatic send_levels(input logic [6:0] levels);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 10);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, levels};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Present one register word; valid stays high for back-to-back writes.
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write the whole register file; junk goes in the unused upper bits and
    // in the spare index.
    task automatic configure(input logic pol, input logic en, input logic [7:0] mag);
        write_reg(CfgPolarity, {7'($urandom_range(0, 127)), pol});
        write_reg(CfgSpare, 8'($urandom_range(0, 255)));
        write_reg(CfgCornerEn, {7'($urandom_range(0, 127)), en});
        write_reg(CfgMagnitude, mag);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pending result, then let the pipeline empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ResultLatency + 2) @(posedge i_clk);
    endtask

    // Pick the active pattern first, leaning on corners, all-on and no-line
    // cases, then turn it into pin levels for the current polarity.
    function automatic logic [6:0] pick_levels(input logic pol);
        logic [6:0] act;
        case ($urandom_range(0, 9))
            0:       act = '0;
            1:       act = LowCornerMask | (7'($urandom_range(0, 127)) & 7'h70);
            2:       act = HighCornerMask | (7'($urandom_range(0, 127)) & 7'h07);
            3:       act = 7'h7F;
            4:       act = 7'(1 << $urandom_range(0, 6));
            default: act = 7'($urandom_range(0, 127));
        endcase
        return pol ? ~act : act;
    endfunction

    // One register setting followed by random samples; optionally ask the
    // receiver for a long hold-off a third of the way in, so the block backs up.
    task automatic run_phase(input logic pol, input logic en, input logic [7:0] mag,
                             input int count, input logic squeeze);
        settle();
        configure(pol, en, mag);
        phases_run++;
        for (int n = 0; n < count; n++) begin
            send_levels(pick_levels(pol));
            if (squeeze && n == count / 3) begin
                hold_toggle <= ~hold_toggle;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples under the reset register values
        for (int n = 0; n < DirectedCount; n++) begin
            send_levels(directed_levels[n]);
        end

        run_phase(1'b1, 1'b1, 8'd255, 160, 1'b1);
        run_phase(1'b0, 1'b0, 8'd0, 160, 1'b0);
        run_phase(1'b1, 1'b0, 8'd128, 150, 1'b0);
        run_phase(1'b0, 1'b1, 8'd0, 150, 1'b1);
        run_phase(1'b0, 1'b1, 8'($urandom_range(1, 254)), 150, 1'b0);
        run_phase(1'b1, 1'b1, 8'($urandom_range(1, 254)), 160, 1'b0);

        settle();
        $display("Run covered %0d sensor samples under reset values and %0d register settings;",
                 checked, phases_run);
        $display("%0d of those results flagged a right-angle corner.", corners);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
